// ===== rtl/hte_pkg.sv =====
// Package with the shared types and constants of the Huffman table encoder.
package hte_pkg;

   localparam int CODE_WIDTH = 16;
   localparam int LEN_BITS   = 5;
   localparam int BYTE_BITS  = 8;
   localparam int SYM_BITS   = 8;
   localparam int PEND_BITS  = BYTE_BITS - 1;
   localparam int CNT_BITS   = 3;

   typedef enum logic [1:0] {
      CMD_LOAD   = 2'd0,
      CMD_ENCODE = 2'd1,
      CMD_FLUSH  = 2'd2
   } cmd_type;

   typedef enum logic {
      STATUS_DATA   = 1'b0,
      STATUS_ABSENT = 1'b1
   } status_type;

   typedef struct packed {
      logic [CODE_WIDTH-1:0] code;
      logic [LEN_BITS-1:0]   length;
   } entry_type;

   typedef struct packed {
      logic [BYTE_BITS-1:0] out_byte;
      status_type           status;
      logic                 last;
   } result_type;

   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } push_type;

endpackage

// ===== rtl/hte_req_if.sv =====
// Input item channel of the Huffman table encoder.
interface hte_req_if;
   logic                           valid;
   logic                           ready;
   logic [1:0]                     command;
   logic [hte_pkg::SYM_BITS-1:0]   symbol;
   logic [hte_pkg::CODE_WIDTH-1:0] entry_code;
   logic [hte_pkg::LEN_BITS-1:0]   entry_length;

   modport source (output valid, command, symbol, entry_code, entry_length, input ready);
   modport sink   (input valid, command, symbol, entry_code, entry_length, output ready);
endinterface

// ===== rtl/hte_rsp_if.sv =====
// Result item channel of the Huffman table encoder.
interface hte_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [hte_pkg::BYTE_BITS-1:0] out_byte;
   logic                          status;
   logic                          last;

   modport source (output valid, out_byte, status, last, input ready);
   modport sink   (input valid, out_byte, status, last, output ready);
endinterface

// ===== rtl/hte_table.sv =====
// Code table memory with per-entry valid bits and a registered read port.
module hte_table #(
   parameter int MAX_CODE_BITS = 16,
   parameter int SYMBOL_COUNT  = 256
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           issue,
   input  logic                           write_en,
   input  logic [hte_pkg::SYM_BITS-1:0]   symbol,
   input  logic [hte_pkg::CODE_WIDTH-1:0] wr_code,
   input  logic [hte_pkg::LEN_BITS-1:0]   wr_length,
   output hte_pkg::entry_type             rd_entry
);
   import hte_pkg::*;

   localparam int ADDR_BITS = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
   localparam int LEN_CAP   = (MAX_CODE_BITS < CODE_WIDTH) ? MAX_CODE_BITS : CODE_WIDTH;

   entry_type               mem [SYMBOL_COUNT];
   logic [SYMBOL_COUNT-1:0] valid_ff;
   entry_type               rd_data_ff;
   logic                    rd_hit_ff;

   logic [ADDR_BITS-1:0] addr;
   logic                 in_range;
   entry_type            wr_entry;

   always_comb begin
      addr     = symbol[ADDR_BITS-1:0];
      in_range = ({1'b0, symbol} < (SYM_BITS + 1)'(SYMBOL_COUNT));
      wr_entry.code   = wr_code;
      wr_entry.length = (wr_length > LEN_BITS'(LEN_CAP)) ? LEN_BITS'(LEN_CAP) : wr_length;
   end

   always_ff @(posedge clock) begin
      if (issue && write_en && in_range) begin
         mem[addr] <= wr_entry;
      end
      if (issue) begin
         rd_data_ff <= mem[addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         rd_hit_ff <= 1'b0;
      end else if (issue) begin
         if (write_en && in_range) begin
            valid_ff[addr] <= 1'b1;
         end
         rd_hit_ff <= in_range && valid_ff[addr];
      end
   end

   // An entry never loaded reads as length zero, which marks the symbol absent.
   always_comb begin
      rd_entry.code   = rd_data_ff.code;
      rd_entry.length = rd_hit_ff ? rd_data_ff.length : '0;
   end

endmodule

// ===== rtl/hte_packer.sv =====
// Second stage: bit accumulator that packs looked-up codes into bytes.
module hte_packer (
   input  logic               clock,
   input  logic               reset,
   input  logic               issue,
   input  hte_pkg::cmd_type   issue_cmd,
   input  hte_pkg::entry_type entry,
   input  logic               q_room,
   output logic               stage_free,
   output hte_pkg::push_type  push
);
   import hte_pkg::*;

   localparam int ACC_BITS = PEND_BITS + CODE_WIDTH;

   logic                 s1_valid_ff, s1_valid_in;
   cmd_type              s1_cmd_ff, s1_cmd_in;
   logic [PEND_BITS-1:0] pend_bits_ff, pend_bits_in;
   logic [CNT_BITS-1:0]  pend_count_ff, pend_count_in;

   logic                 fire;
   logic [CODE_WIDTH:0]  code_mask;
   logic [ACC_BITS-1:0]  acc;
   logic [LEN_BITS-1:0]  total;
   logic [LEN_BITS-1:0]  rem;
   logic [BYTE_BITS-1:0] rem_mask;
   logic [1:0]           n_bytes;
   logic [BYTE_BITS-1:0] byte0, byte1;
   logic [3:0]           pad_shift;

   assign fire       = s1_valid_ff && q_room;
   assign stage_free = !s1_valid_ff || q_room;

   always_comb begin
      s1_valid_in = issue ? 1'b1 : (fire ? 1'b0 : s1_valid_ff);
      s1_cmd_in   = issue ? issue_cmd : s1_cmd_ff;
   end

   // Encode datapath: new code goes below the pending bits, whole bytes come off the top.
   always_comb begin
      code_mask = ((CODE_WIDTH + 1)'(1) << entry.length) - (CODE_WIDTH + 1)'(1);
      acc       = (ACC_BITS'(pend_bits_ff) << entry.length)
                | ACC_BITS'(entry.code & code_mask[CODE_WIDTH-1:0]);
      total     = LEN_BITS'(pend_count_ff) + entry.length;
      byte0     = BYTE_BITS'(acc >> (total - LEN_BITS'(BYTE_BITS)));
      byte1     = BYTE_BITS'(acc >> (total - LEN_BITS'(2 * BYTE_BITS)));
      if (total >= LEN_BITS'(2 * BYTE_BITS)) begin
         n_bytes = 2'd2;
         rem     = total - LEN_BITS'(2 * BYTE_BITS);
      end else if (total >= LEN_BITS'(BYTE_BITS)) begin
         n_bytes = 2'd1;
         rem     = total - LEN_BITS'(BYTE_BITS);
      end else begin
         n_bytes = 2'd0;
         rem     = total;
      end
      rem_mask  = (BYTE_BITS'(1) << rem[CNT_BITS-1:0]) - BYTE_BITS'(1);
      pad_shift = 4'(BYTE_BITS) - {1'b0, pend_count_ff};
   end

   always_comb begin
      push.count           = 2'd0;
      push.first.out_byte  = '0;
      push.first.status    = STATUS_DATA;
      push.first.last      = 1'b1;
      push.second.out_byte = byte1;
      push.second.status   = STATUS_DATA;
      push.second.last     = 1'b1;
      pend_bits_in         = pend_bits_ff;
      pend_count_in        = pend_count_ff;
      if (fire) begin
         unique case (s1_cmd_ff)
            CMD_ENCODE: begin
               if (entry.length == '0) begin
                  push.count        = 2'd1;
                  push.first.status = STATUS_ABSENT;
               end else begin
                  push.count          = n_bytes;
                  push.first.out_byte = byte0;
                  push.first.last     = (n_bytes == 2'd1);
                  pend_bits_in        = acc[PEND_BITS-1:0] & rem_mask[PEND_BITS-1:0];
                  pend_count_in       = rem[CNT_BITS-1:0];
               end
            end
            CMD_FLUSH: begin
               if (pend_count_ff != '0) begin
                  push.count          = 2'd1;
                  push.first.out_byte = BYTE_BITS'(BYTE_BITS'(pend_bits_ff) << pad_shift);
                  pend_bits_in        = '0;
                  pend_count_in       = '0;
               end
            end
            default: begin
               push.count = 2'd0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         s1_cmd_ff     <= CMD_LOAD;
         pend_bits_ff  <= '0;
         pend_count_ff <= '0;
      end else begin
         s1_valid_ff   <= s1_valid_in;
         s1_cmd_ff     <= s1_cmd_in;
         pend_bits_ff  <= pend_bits_in;
         pend_count_ff <= pend_count_in;
      end
   end

`ifndef SYNTHESIS
   a_pend_hold: assert property (@(posedge clock) disable iff (reset)
      !fire |=> $stable(pend_count_ff) && $stable(pend_bits_ff))
      else $error("pending bits changed without a processed item");
   a_flush_clears: assert property (@(posedge clock) disable iff (reset)
      (fire && s1_cmd_ff == CMD_FLUSH) |=> (pend_count_ff == '0))
      else $error("flush left bits pending");
   a_two_only_encode: assert property (@(posedge clock) disable iff (reset)
      (push.count == 2'd2) |-> (s1_cmd_ff == CMD_ENCODE && push.first.last == 1'b0))
      else $error("two results from a non-encode item");
`endif

endmodule

// ===== rtl/hte_out_queue.sv =====
// Two-entry result queue that decouples the packer from the result channel.
module hte_out_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  hte_pkg::push_type    push,
   input  logic                 pop,
   output logic                 out_valid,
   output hte_pkg::result_type  out_data,
   output logic                 room
);
   import hte_pkg::*;

   result_type entry_ff [2];
   logic       rd_ptr_ff, rd_ptr_in;
   logic       wr_ptr_ff, wr_ptr_in;
   logic [1:0] count_ff, count_in;

   assign out_valid = (count_ff != 2'd0);
   assign out_data  = entry_ff[rd_ptr_ff];
   // Room for a full pair of results, counting the one leaving this cycle.
   assign room      = (count_ff == 2'd0) || (count_ff == 2'd1 && pop);

   always_comb begin
      rd_ptr_in = rd_ptr_ff ^ pop;
      wr_ptr_in = wr_ptr_ff ^ push.count[0];
      count_in  = count_ff + push.count - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         entry_ff[~wr_ptr_ff] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== rtl/huffman_table_encoder_top.sv =====
// Top level of the static-table Huffman encoder.
// rsp_chan valid follows the table read register, the packer and the result queue.
// Throughput: one item per cycle while each yields at most one result and rsp_chan is ready;
// a two-byte encode holds the result port for both results, and any item, loads included,
// waits in the packer while the two-entry result queue lacks room for a pair of results.
// Synchronous active-high reset clears table valid bits, pending bits and queue.
module huffman_table_encoder_top #(
   parameter int MAX_CODE_BITS = 16,
   parameter int SYMBOL_COUNT  = 256
) (
   input logic    clock,
   input logic    reset,
   hte_req_if.sink   req_chan,
   hte_rsp_if.source rsp_chan
);
   import hte_pkg::*;

   // Stage 0 is the table: a load item writes its entry, any other item reads the entry
   // of its symbol into the memory's output register. Stage 1 is the packer, which works on
   // that registered entry together with the pending bits and hands zero to two results to
   // the output queue. A load writes at acceptance, so an encode of the same symbol in the
   // next cycle already reads the new entry and no forwarding is needed.

   logic       issue;
   logic       stage_free;
   logic       q_room;
   logic       pop;
   cmd_type    issue_cmd;
   entry_type  rd_entry;
   push_type   push;
   result_type out_data;

   assign issue_cmd      = cmd_type'(req_chan.command);
   assign req_chan.ready = stage_free;
   assign issue          = req_chan.valid && stage_free;
   assign pop            = rsp_chan.valid && rsp_chan.ready;

   hte_table #(
      .MAX_CODE_BITS (MAX_CODE_BITS),
      .SYMBOL_COUNT  (SYMBOL_COUNT)
   ) u_table (
      .clock     (clock),
      .reset     (reset),
      .issue     (issue),
      .write_en  (issue_cmd == CMD_LOAD),
      .symbol    (req_chan.symbol),
      .wr_code   (req_chan.entry_code),
      .wr_length (req_chan.entry_length),
      .rd_entry  (rd_entry)
   );

   // The packer holds its item until the queue has room for a full pair of results.
   hte_packer u_packer (
      .clock      (clock),
      .reset      (reset),
      .issue      (issue),
      .issue_cmd  (issue_cmd),
      .entry      (rd_entry),
      .q_room     (q_room),
      .stage_free (stage_free),
      .push       (push)
   );

   hte_out_queue u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (pop),
      .out_valid (rsp_chan.valid),
      .out_data  (out_data),
      .room      (q_room)
   );

   assign rsp_chan.out_byte = out_data.out_byte;
   assign rsp_chan.status   = out_data.status;
   assign rsp_chan.last     = out_data.last;

endmodule
